FILE: rtl/rss_pkg.sv
// Radio seek sequencer: shared types, codes and constants.
// No dependencies; every rtl file refers to it by scoped names.
package rss_pkg;

    localparam int FREQ_W   = 16;
    localparam int LEVEL_W  = 7;
    localparam int PROBE_W  = 2;
    localparam int CMD_W    = 2;
    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;
    localparam int PEAK_PROBES_DEF = 3;

    // command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT   = 2'd2;

    // action codes (m_tuser)
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TUNE    = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BAND_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BAND_HIGH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_STEP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FM_MODE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STR_FM    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STR_AM    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SNR       = 3'd6;

    localparam logic [FREQ_W-1:0]  BAND_LOW_RST  = 16'd8750;
    localparam logic [FREQ_W-1:0]  BAND_HIGH_RST = 16'd10800;
    localparam logic [FREQ_W-1:0]  BAND_STEP_RST = 16'd10;
    localparam logic               FM_MODE_RST   = 1'b1;
    localparam logic [LEVEL_W-1:0] STR_FM_RST    = 7'd15;
    localparam logic [LEVEL_W-1:0] STR_AM_RST    = 7'd25;
    localparam logic [LEVEL_W-1:0] SNR_RST       = 7'd8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_PROBE
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  band_low;
        logic [FREQ_W-1:0]  band_high;
        logic [FREQ_W-1:0]  band_step;
        logic               fm_mode;
        logic [LEVEL_W-1:0] str_fm;
        logic [LEVEL_W-1:0] str_am;
        logic [LEVEL_W-1:0] snr_limit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

endpackage

FILE: rtl/rss_regs.sv
// Configuration register file behind the APB port.
// Depends on rss_pkg.
module rss_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rss_pkg::ADDR_W-1:0]  paddr,
    input  logic [rss_pkg::DATA_W-1:0]  pwdata,
    output logic [rss_pkg::DATA_W-1:0]  prdata,
    output rss_pkg::cfg_t               cfg
);

    rss_pkg::cfg_t                  cfg_reg;
    rss_pkg::cfg_t                  cfg_next;
    logic [rss_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign idx   = paddr[rss_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                rss_pkg::REG_BAND_LOW:  cfg_next.band_low  = pwdata[rss_pkg::FREQ_W-1:0];
                rss_pkg::REG_BAND_HIGH: cfg_next.band_high = pwdata[rss_pkg::FREQ_W-1:0];
                rss_pkg::REG_BAND_STEP: cfg_next.band_step = pwdata[rss_pkg::FREQ_W-1:0];
                rss_pkg::REG_FM_MODE:   cfg_next.fm_mode   = pwdata[0];
                rss_pkg::REG_STR_FM:    cfg_next.str_fm    = pwdata[rss_pkg::LEVEL_W-1:0];
                rss_pkg::REG_STR_AM:    cfg_next.str_am    = pwdata[rss_pkg::LEVEL_W-1:0];
                rss_pkg::REG_SNR:       cfg_next.snr_limit = pwdata[rss_pkg::LEVEL_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rss_pkg::REG_BAND_LOW:  prdata = 32'(cfg_reg.band_low);
            rss_pkg::REG_BAND_HIGH: prdata = 32'(cfg_reg.band_high);
            rss_pkg::REG_BAND_STEP: prdata = 32'(cfg_reg.band_step);
            rss_pkg::REG_FM_MODE:   prdata = 32'(cfg_reg.fm_mode);
            rss_pkg::REG_STR_FM:    prdata = 32'(cfg_reg.str_fm);
            rss_pkg::REG_STR_AM:    prdata = 32'(cfg_reg.str_am);
            rss_pkg::REG_SNR:       prdata = 32'(cfg_reg.snr_limit);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low  <= rss_pkg::BAND_LOW_RST;
            cfg_reg.band_high <= rss_pkg::BAND_HIGH_RST;
            cfg_reg.band_step <= rss_pkg::BAND_STEP_RST;
            cfg_reg.fm_mode   <= rss_pkg::FM_MODE_RST;
            cfg_reg.str_fm    <= rss_pkg::STR_FM_RST;
            cfg_reg.str_am    <= rss_pkg::STR_AM_RST;
            cfg_reg.snr_limit <= rss_pkg::SNR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/rss_div.sv
// Restoring divider, one quotient bit per cycle; computes the step budget.
// Depends on rss_pkg.
module rss_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rss_pkg::FREQ_W-1:0]  dividend,
    input  logic [rss_pkg::FREQ_W-1:0]  divisor,
    output logic [rss_pkg::FREQ_W-1:0]  quotient,
    output logic                        done
);

    localparam int W     = rss_pkg::FREQ_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic [W:0]       trial;

    assign trial    = {rem_reg, quo_reg[W-1]} - {1'b0, divisor};
    assign quotient = quo_reg;
    assign done     = run_reg && (cnt_reg == '0);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(W);
            run_next = 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: rtl/rss_datapath.sv
// Seek datapath: input latch, seek state, step unit, budget divider, result register.
// Depends on rss_pkg and rss_div.
module rss_datapath
#(
    parameter int PEAK_PROBES = rss_pkg::PEAK_PROBES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rss_pkg::cfg_t                 cfg,
    input  rss_pkg::ctrl_cmd_t            cmd,
    output rss_pkg::dp_status_t           status,
    input  logic [rss_pkg::CMD_W-1:0]     in_user,
    input  logic [rss_pkg::S_DATA_W-1:0]  in_data,
    output logic [rss_pkg::ACT_W-1:0]     out_user,
    output logic [rss_pkg::M_DATA_W-1:0]  out_data
);

    localparam int FW = rss_pkg::FREQ_W;
    localparam int LW = rss_pkg::LEVEL_W;
    localparam int PW = rss_pkg::PROBE_W;
    localparam logic [PW-1:0] PROBE_LIMIT = PW'(PEAK_PROBES);

    function automatic logic [FW-1:0] next_freq(
        input logic [FW-1:0] f,
        input logic          down,
        input logic [FW-1:0] low,
        input logic [FW-1:0] high,
        input logic [FW-1:0] step
    );
        logic [FW:0]   sum;
        logic [FW:0]   diff;
        logic [FW-1:0] res;
        sum  = {1'b0, f} + {1'b0, step};
        diff = {1'b0, f} - {1'b0, step};
        if (down)
            res = (diff[FW] || (diff[FW-1:0] < low)) ? high : diff[FW-1:0];
        else
            res = (sum > {1'b0, high}) ? low : sum[FW-1:0];
        return res;
    endfunction

    // latched input beat
    logic [rss_pkg::CMD_W-1:0] cmd_reg;
    logic                      down_reg;
    logic [FW-1:0]             sfreq_reg;
    logic [LW-1:0]             str_reg;
    logic [LW-1:0]             snr_reg;

    // seek state
    rss_pkg::phase_t phase_reg, phase_next;
    logic            going_down_reg, going_down_next;
    logic [FW-1:0]   origin_reg, origin_next;
    logic [FW-1:0]   cursor_reg, cursor_next;
    logic [FW-1:0]   steps_left_reg, steps_left_next;
    logic [FW-1:0]   peak_freq_reg, peak_freq_next;
    logic [LW-1:0]   peak_str_reg, peak_str_next;
    logic [FW-1:0]   probe_freq_reg, probe_freq_next;
    logic [PW-1:0]   probes_done_reg, probes_done_next;

    // result beat
    logic [rss_pkg::ACT_W-1:0] act_reg, act_next;
    logic [FW-1:0]             freq_reg, freq_next;
    logic                      busy_reg, busy_next;

    logic [FW-1:0] quotient;
    logic          div_done;
    logic [FW-1:0] nf_in;
    logic          nf_down;
    logic [FW-1:0] nf;
    logic [LW-1:0] str_lim;
    logic          hit;
    logic [PW-1:0] pd_inc;

    rss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cfg.band_high - cfg.band_low),
        .divisor  (cfg.band_step),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.need_div = (cmd_reg == rss_pkg::CMD_START) && (phase_reg == rss_pkg::PH_IDLE)
                             && (cfg.band_step != '0);
    assign status.div_done = div_done;

    // one shared step unit
    always_comb
    begin
        if (cmd_reg == rss_pkg::CMD_START)
        begin
            nf_in   = sfreq_reg;
            nf_down = down_reg;
        end
        else
        begin
            nf_in   = (phase_reg == rss_pkg::PH_RUN) ? cursor_reg : probe_freq_reg;
            nf_down = going_down_reg;
        end
        nf = next_freq(nf_in, nf_down, cfg.band_low, cfg.band_high, cfg.band_step);
    end

    assign str_lim = cfg.fm_mode ? cfg.str_fm : cfg.str_am;
    assign hit     = (str_reg >= str_lim) && (snr_reg >= cfg.snr_limit);
    assign pd_inc  = probes_done_reg + 1'b1;

    always_comb
    begin
        phase_next       = phase_reg;
        going_down_next  = going_down_reg;
        origin_next      = origin_reg;
        cursor_next      = cursor_reg;
        steps_left_next  = steps_left_reg;
        peak_freq_next   = peak_freq_reg;
        peak_str_next    = peak_str_reg;
        probe_freq_next  = probe_freq_reg;
        probes_done_next = probes_done_reg;
        act_next         = rss_pkg::ACT_NONE;
        freq_next        = '0;

        case (cmd_reg)
            rss_pkg::CMD_START:
            begin
                if (phase_reg == rss_pkg::PH_IDLE && cfg.band_step != '0)
                begin
                    going_down_next = down_reg;
                    origin_next     = sfreq_reg;
                    cursor_next     = nf;
                    steps_left_next = quotient + FW'(2);
                    phase_next      = rss_pkg::PH_RUN;
                    act_next        = rss_pkg::ACT_MEASURE;
                    freq_next       = nf;
                end
            end
            rss_pkg::CMD_ABORT:
            begin
                if (phase_reg != rss_pkg::PH_IDLE)
                begin
                    phase_next = rss_pkg::PH_IDLE;
                    act_next   = rss_pkg::ACT_TUNE;
                    freq_next  = origin_reg;
                end
            end
            rss_pkg::CMD_MEASURE:
            begin
                if (phase_reg == rss_pkg::PH_RUN)
                begin
                    if (hit)
                    begin
                        peak_freq_next   = cursor_reg;
                        peak_str_next    = str_reg;
                        probes_done_next = '0;
                        if (('0 >= PROBE_LIMIT) || (nf == origin_reg))
                        begin
                            phase_next = rss_pkg::PH_IDLE;
                            act_next   = rss_pkg::ACT_TUNE;
                            freq_next  = cursor_reg;
                        end
                        else
                        begin
                            probe_freq_next = nf;
                            phase_next      = rss_pkg::PH_PROBE;
                            act_next        = rss_pkg::ACT_MEASURE;
                            freq_next       = nf;
                        end
                    end
                    else if (steps_left_reg == '0 || cursor_reg == origin_reg)
                    begin
                        phase_next = rss_pkg::PH_IDLE;
                        act_next   = rss_pkg::ACT_TUNE;
                        freq_next  = origin_reg;
                    end
                    else
                    begin
                        cursor_next     = nf;
                        steps_left_next = steps_left_reg - 1'b1;
                        act_next        = rss_pkg::ACT_MEASURE;
                        freq_next       = nf;
                    end
                end
                else if (phase_reg == rss_pkg::PH_PROBE)
                begin
                    probes_done_next = pd_inc;
                    if (str_reg > peak_str_reg)
                    begin
                        peak_freq_next = probe_freq_reg;
                        peak_str_next  = str_reg;
                        if ((pd_inc >= PROBE_LIMIT) || (nf == origin_reg))
                        begin
                            phase_next = rss_pkg::PH_IDLE;
                            act_next   = rss_pkg::ACT_TUNE;
                            freq_next  = probe_freq_reg;
                        end
                        else
                        begin
                            probe_freq_next = nf;
                            act_next        = rss_pkg::ACT_MEASURE;
                            freq_next       = nf;
                        end
                    end
                    else
                    begin
                        phase_next = rss_pkg::PH_IDLE;
                        act_next   = rss_pkg::ACT_TUNE;
                        freq_next  = peak_freq_reg;
                    end
                end
            end
            default:
            begin
                act_next = rss_pkg::ACT_NONE;
            end
        endcase

        busy_next = (phase_next != rss_pkg::PH_IDLE);
    end

    assign out_user = act_reg;
    assign out_data = {7'b0, busy_reg, freq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rss_pkg::PH_IDLE;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_user;
            down_reg  <= in_data[0];
            sfreq_reg <= in_data[FW:1];
            str_reg   <= in_data[FW+LW:FW+1];
            snr_reg   <= in_data[FW+2*LW:FW+LW+1];
        end
        if (cmd.exec)
        begin
            going_down_reg  <= going_down_next;
            origin_reg      <= origin_next;
            cursor_reg      <= cursor_next;
            steps_left_reg  <= steps_left_next;
            peak_freq_reg   <= peak_freq_next;
            peak_str_reg    <= peak_str_next;
            probe_freq_reg  <= probe_freq_next;
            probes_done_reg <= probes_done_next;
            act_reg         <= act_next;
            freq_reg        <= freq_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

FILE: rtl/rss_ctrl.sv
// Sequencing controller: input handshake, divider wait, result handoff.
// Depends on rss_pkg.
module rss_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rss_pkg::dp_status_t  status,
    output rss_pkg::ctrl_cmd_t   cmd
);

    rss_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_exec;

    assign can_exec  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rss_pkg::S_IDLE:   if (in_valid) state_next = rss_pkg::S_DECODE;
            rss_pkg::S_DECODE: state_next = status.need_div ? rss_pkg::S_DIV : rss_pkg::S_EXEC;
            rss_pkg::S_DIV:    if (status.div_done) state_next = rss_pkg::S_EXEC;
            rss_pkg::S_EXEC:   if (can_exec) state_next = rss_pkg::S_IDLE;
            default:           state_next = rss_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.exec      = 1'b0;
        unique case (state_reg)
            rss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rss_pkg::S_DECODE: cmd.div_start = status.need_div;
            rss_pkg::S_DIV:    cmd.exec      = 1'b0;
            rss_pkg::S_EXEC:   cmd.exec      = can_exec;
            default:           cmd.exec      = 1'b0;
        endcase
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/radio_seek_sequencer_top.sv
// Radio seek sequencer top level.
// A beat is latched in IDLE, decoded in DECODE, then executed into the result register in
// EXEC, which waits for m_tready while a result is pending; a start that arms a run first
// waits in DIV for the 16-step budget divider (one quotient bit per cycle). Beats are taken
// one at a time, but a new beat is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low): run idle, registers at defaults, no result pending.
module radio_seek_sequencer_top
#(
    parameter int PEAK_PROBES = rss_pkg::PEAK_PROBES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rss_pkg::ADDR_W-1:0]    paddr,
    input  logic [rss_pkg::DATA_W-1:0]    pwdata,
    output logic [rss_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rss_pkg::S_DATA_W-1:0]  s_tdata,  // seek_down, start_freq, strength, noise_margin
    input  logic [rss_pkg::CMD_W-1:0]     s_tuser,  // command
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rss_pkg::M_DATA_W-1:0]  m_tdata,  // freq, busy_res
    output logic [rss_pkg::ACT_W-1:0]     m_tuser   // action
);

    rss_pkg::cfg_t       cfg;
    rss_pkg::ctrl_cmd_t  cmd;
    rss_pkg::dp_status_t status;

    assign pready = 1'b1;

    rss_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rss_datapath #(
        .PEAK_PROBES (PEAK_PROBES)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .in_user  (s_tuser),
        .in_data  (s_tdata),
        .out_user (m_tuser),
        .out_data (m_tdata)
    );

endmodule
